// File: rtl/bced_pkg.sv
// Shared types and constants for the button click event detector.
// Holds the state and event encodings, register indexes and reset values.
// No dependencies.
`default_nettype none

package bced_pkg;

    localparam int TICK_W  = 16;
    localparam int CLICK_W = 8;
    localparam int IDX_W   = 3;
    localparam int DATA_W  = 16;

    typedef enum logic [2:0] {
        EV_NONE  = 3'd0,
        EV_EDGE  = 3'd1,
        EV_HELD  = 3'd2,
        EV_SHORT = 3'd3,
        EV_MULTI = 3'd4,
        EV_LONG  = 3'd5
    } t_event;

    typedef enum logic [7:0] {
        ST_IDLE          = 8'b0000_0001,
        ST_PRESS_EDGE    = 8'b0000_0010,
        ST_PRESS_CHECK   = 8'b0000_0100,
        ST_PRESS_HELD    = 8'b0000_1000,
        ST_RELEASE_CHECK = 8'b0001_0000,
        ST_SHORT         = 8'b0010_0000,
        ST_MULTI         = 8'b0100_0000,
        ST_LONG          = 8'b1000_0000
    } t_state;

    localparam logic [IDX_W-1:0] REG_PIN_INVERT    = 3'd0;
    localparam logic [IDX_W-1:0] REG_SHORT_TICKS   = 3'd1;
    localparam logic [IDX_W-1:0] REG_LONG_TICKS    = 3'd2;
    localparam logic [IDX_W-1:0] REG_HOLD_TICKS    = 3'd3;
    localparam logic [IDX_W-1:0] REG_RELEASE_TICKS = 3'd4;
    localparam logic [IDX_W-1:0] REG_MULTI_COUNT   = 3'd5;

    localparam logic [TICK_W-1:0]  RST_SHORT_TICKS   = 16'd2;
    localparam logic [TICK_W-1:0]  RST_LONG_TICKS    = 16'd100;
    localparam logic [TICK_W-1:0]  RST_HOLD_TICKS    = 16'd50;
    localparam logic [TICK_W-1:0]  RST_RELEASE_TICKS = 16'd30;
    localparam logic [CLICK_W-1:0] RST_MULTI_COUNT   = 8'd3;

    typedef struct packed {
        logic               pin_invert;
        logic [TICK_W-1:0]  short_ticks;
        logic [TICK_W-1:0]  long_ticks;
        logic [TICK_W-1:0]  hold_ticks;
        logic [TICK_W-1:0]  release_ticks;
        logic [CLICK_W-1:0] multi_count;
    } t_cfg;

    typedef struct packed {
        t_event event_code;
        logic   pressed;
    } t_result;

endpackage

`default_nettype wire

// File: rtl/button_click_event_detector.sv
// Button click event detector: top level with config bank, click state machine
// and output register. Depends on bced_pkg, bced_cfg_regs and bced_fsm.
//
// Each input beat is one tick carrying the raw pin level of a single button. The
// level is corrected for polarity (pin_invert), an edge is detected against the
// previous tick, and a one-hot state machine counts press and release ticks and
// clicks. Every tick yields exactly one result beat: event_code (0 none, 1 press
// edge, 2 press held, 3 short, 4 multi, 5 long click) and the corrected level.
// Events appear one tick after the decision that causes them. The result beat is
// registered, and a new tick is taken every cycle unless the input stalls: the
// decision is a compare and increment of a 16-bit tick and an 8-bit click counter
// ahead of a single result register. The input stalls only while that register
// is full and the output is stalled. Configuration writes are always ready and
// take effect at the next tick; write them only while no tick is in flight.
`default_nettype none

module button_click_event_detector (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    // tick input
    input  wire logic                        i_in_valid,
    output wire logic                        o_in_stall,
    input  wire logic                        i_pin_level,
    // result output
    output wire logic                        o_out_valid,
    input  wire logic                        i_out_stall,
    output wire logic [2:0]                  o_event_code,
    output wire logic                        o_pressed,
    // configuration writes
    input  wire logic                        i_cfg_valid,
    output wire logic                        o_cfg_ready,
    input  wire logic [bced_pkg::IDX_W-1:0]  i_cfg_index,
    input  wire logic [bced_pkg::DATA_W-1:0] i_cfg_data
);

    bced_pkg::t_cfg    cfg;
    bced_pkg::t_result result;
    bced_pkg::t_result r_result;
    logic              r_out_valid;
    logic              accept;

    // Take a tick unless the held result is still waiting downstream.
    assign o_in_stall  = r_out_valid & i_out_stall;
    assign accept      = i_in_valid & ~o_in_stall;
    assign o_cfg_ready = 1'b1;

    bced_cfg_regs u_cfg_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr_en (i_cfg_valid & o_cfg_ready),
        .i_index (i_cfg_index),
        .i_data  (i_cfg_data),
        .o_cfg   (cfg)
    );

    bced_fsm u_fsm (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_pin_level (i_pin_level),
        .i_cfg       (cfg),
        .o_result    (result)
    );

    // Result register: load on every accepted tick, drop valid once taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (accept) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_result <= result;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_event_code = r_result.event_code;
    assign o_pressed    = r_result.pressed;

    // Every accepted tick produces a result beat in the next cycle.
    a_accept_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> o_out_valid)
        else $error("accepted tick did not produce a result");

    // Input stalls only behind a held result.
    a_stall_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (o_out_valid && i_out_stall))
        else $error("input stalled with result register free");

    // Only defined event codes reach the output.
    a_event_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_event_code <= bced_pkg::EV_LONG))
        else $error("undefined event code on output");

endmodule

`default_nettype wire

// File: rtl/bced_cfg_regs.sv
// Configuration register bank of the button click event detector.
// Depends on bced_pkg for indexes, reset values and the t_cfg struct.
`default_nettype none

module bced_cfg_regs (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_wr_en,
    input  wire logic [bced_pkg::IDX_W-1:0]    i_index,
    input  wire logic [bced_pkg::DATA_W-1:0]   i_data,
    output bced_pkg::t_cfg                     o_cfg
);

    bced_pkg::t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.pin_invert    <= 1'b1;
            r_cfg.short_ticks   <= bced_pkg::RST_SHORT_TICKS;
            r_cfg.long_ticks    <= bced_pkg::RST_LONG_TICKS;
            r_cfg.hold_ticks    <= bced_pkg::RST_HOLD_TICKS;
            r_cfg.release_ticks <= bced_pkg::RST_RELEASE_TICKS;
            r_cfg.multi_count   <= bced_pkg::RST_MULTI_COUNT;
        end else if (i_wr_en) begin
            // keep only the low bits of each beat, drop unknown indexes
            case (i_index)
                bced_pkg::REG_PIN_INVERT:    r_cfg.pin_invert    <= i_data[0];
                bced_pkg::REG_SHORT_TICKS:   r_cfg.short_ticks   <= i_data;
                bced_pkg::REG_LONG_TICKS:    r_cfg.long_ticks    <= i_data;
                bced_pkg::REG_HOLD_TICKS:    r_cfg.hold_ticks    <= i_data;
                bced_pkg::REG_RELEASE_TICKS: r_cfg.release_ticks <= i_data;
                bced_pkg::REG_MULTI_COUNT:
                    r_cfg.multi_count <= i_data[bced_pkg::CLICK_W-1:0];
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

// File: rtl/bced_fsm.sv
// Click state machine with tick and click counters for one button.
// Depends on bced_pkg for state and event codes and the config struct.
`default_nettype none

module bced_fsm (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_accept,
    input  wire logic            i_pin_level,
    input  wire bced_pkg::t_cfg  i_cfg,
    output bced_pkg::t_result    o_result
);

    localparam logic [bced_pkg::TICK_W-1:0]  TICK_MAX  = '1;
    localparam logic [bced_pkg::CLICK_W-1:0] CLICK_MAX = '1;
    localparam logic [bced_pkg::TICK_W-1:0]  TICK_ONE  = bced_pkg::TICK_W'(1);
    localparam logic [bced_pkg::CLICK_W-1:0] CLICK_ONE = bced_pkg::CLICK_W'(1);

    bced_pkg::t_state                r_state, n_state;
    logic [bced_pkg::TICK_W-1:0]     r_tick, n_tick;
    logic [bced_pkg::CLICK_W-1:0]    r_click, n_click;
    bced_pkg::t_event                r_pend, n_pend;
    logic                            r_last, n_last;

    logic                            level;
    logic                            edge_det;
    logic [bced_pkg::TICK_W-1:0]     tick_inc;
    logic [bced_pkg::CLICK_W-1:0]    click_inc;
    bced_pkg::t_event                code;

    always_comb begin
        level     = i_pin_level ^ i_cfg.pin_invert;
        edge_det  = level & ~r_last;
        tick_inc  = (r_tick == TICK_MAX) ? r_tick : r_tick + TICK_ONE;
        click_inc = (r_click == CLICK_MAX) ? r_click : r_click + CLICK_ONE;

        n_state = r_state;
        n_tick  = r_tick;
        n_click = r_click;
        n_pend  = r_pend;
        n_last  = level;
        code    = bced_pkg::EV_NONE;

        case (r_state)
            bced_pkg::ST_IDLE: begin
                n_tick = '0;
                if (edge_det) begin
                    n_click = click_inc;
                    n_pend  = bced_pkg::EV_EDGE;
                    n_state = bced_pkg::ST_PRESS_EDGE;
                end else begin
                    n_click = '0;
                    n_pend  = bced_pkg::EV_NONE;
                end
            end
            bced_pkg::ST_PRESS_CHECK: begin
                if (!level) begin
                    n_state = bced_pkg::ST_RELEASE_CHECK;
                    if (r_click >= i_cfg.multi_count) begin
                        n_tick  = '0;
                        n_click = '0;
                        n_pend  = bced_pkg::EV_MULTI;
                        n_state = bced_pkg::ST_MULTI;
                    end else if (r_tick >= i_cfg.long_ticks) begin
                        n_tick = '0;
                        n_pend = bced_pkg::EV_LONG;
                    end else if (r_tick >= i_cfg.short_ticks) begin
                        n_tick = '0;
                        n_pend = bced_pkg::EV_SHORT;
                    end else begin
                        // burr: keep the counts
                        n_pend = bced_pkg::EV_NONE;
                    end
                end else begin
                    n_tick = tick_inc;
                    if (tick_inc >= i_cfg.hold_ticks && r_pend != bced_pkg::EV_HELD) begin
                        n_pend  = bced_pkg::EV_HELD;
                        n_state = bced_pkg::ST_PRESS_HELD;
                    end
                end
            end
            bced_pkg::ST_RELEASE_CHECK: begin
                if (edge_det) begin
                    if (r_pend != bced_pkg::EV_NONE) begin
                        n_click = click_inc;
                        n_tick  = '0;
                    end
                    n_state = bced_pkg::ST_PRESS_CHECK;
                end else begin
                    n_tick = tick_inc;
                    if (tick_inc > i_cfg.release_ticks) begin
                        n_tick  = '0;
                        n_click = '0;
                        if (r_pend == bced_pkg::EV_SHORT) begin
                            n_state = bced_pkg::ST_SHORT;
                        end else if (r_pend == bced_pkg::EV_LONG) begin
                            n_state = bced_pkg::ST_LONG;
                        end else begin
                            n_state = bced_pkg::ST_IDLE;
                        end
                    end
                end
            end
            bced_pkg::ST_PRESS_EDGE, bced_pkg::ST_PRESS_HELD: begin
                code    = r_pend;
                n_state = bced_pkg::ST_PRESS_CHECK;
            end
            bced_pkg::ST_SHORT, bced_pkg::ST_MULTI, bced_pkg::ST_LONG: begin
                code    = r_pend;
                n_state = bced_pkg::ST_IDLE;
            end
            default: begin
                n_state = bced_pkg::ST_IDLE;
            end
        endcase

        o_result.event_code = code;
        o_result.pressed    = level;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= bced_pkg::ST_IDLE;
            r_tick  <= '0;
            r_click <= '0;
            r_pend  <= bced_pkg::EV_NONE;
            r_last  <= 1'b0;
        end else if (i_accept) begin
            r_state <= n_state;
            r_tick  <= n_tick;
            r_click <= n_click;
            r_pend  <= n_pend;
            r_last  <= n_last;
        end
    end

    // Idle always clears the tick count.
    a_idle_clears_tick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_accept && r_state == bced_pkg::ST_IDLE) |=> (r_tick == '0))
        else $error("tick count not cleared after idle");

    // Decision states never emit an event.
    a_no_event_in_check: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == bced_pkg::ST_IDLE || r_state == bced_pkg::ST_PRESS_CHECK ||
         r_state == bced_pkg::ST_RELEASE_CHECK) |-> (code == bced_pkg::EV_NONE))
        else $error("event emitted outside a dispatch state");

    // Dispatch states last one beat.
    a_dispatch_one_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_accept && (r_state == bced_pkg::ST_SHORT || r_state == bced_pkg::ST_MULTI ||
         r_state == bced_pkg::ST_LONG)) |=> (r_state == bced_pkg::ST_IDLE))
        else $error("dispatch state did not return to idle");

endmodule

`default_nettype wire

// File: tb/tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for button_click_event_detector: tick stimulus, settings
// sweeps and a tick-exact click tracker that predicts every result beat.
// Depends on bced_pkg and the button_click_event_detector RTL.

module tb;

    // Tracks one button the way the detector should: polarity, edge, state machine
    // and counters, plus the queue of result beats still owed by the block.
    class button_tracker;
        bced_pkg::t_cfg    cfg;
        bced_pkg::t_state  state;
        logic [15:0]       ticks;
        logic [7:0]        clicks;
        bced_pkg::t_event  pend;
        logic              last_level;
        bced_pkg::t_result owed[$];

        function new();
            cfg.pin_invert    = 1'b1;
            cfg.short_ticks   = bced_pkg::RST_SHORT_TICKS;
            cfg.long_ticks    = bced_pkg::RST_LONG_TICKS;
            cfg.hold_ticks    = bced_pkg::RST_HOLD_TICKS;
            cfg.release_ticks = bced_pkg::RST_RELEASE_TICKS;
            cfg.multi_count   = bced_pkg::RST_MULTI_COUNT;
            state      = bced_pkg::ST_IDLE;
            ticks      = '0;
            clicks     = '0;
            pend       = bced_pkg::EV_NONE;
            last_level = 1'b0;
        endfunction

        // Keep only the low bits of a write, up to the register's width.
        function void write_reg(logic [bced_pkg::IDX_W-1:0] idx,
                                logic [bced_pkg::DATA_W-1:0] data);
            case (idx)
                bced_pkg::REG_PIN_INVERT:    cfg.pin_invert    = data[0];
                bced_pkg::REG_SHORT_TICKS:   cfg.short_ticks   = data;
                bced_pkg::REG_LONG_TICKS:    cfg.long_ticks    = data;
                bced_pkg::REG_HOLD_TICKS:    cfg.hold_ticks    = data;
                bced_pkg::REG_RELEASE_TICKS: cfg.release_ticks = data;
                bced_pkg::REG_MULTI_COUNT:   cfg.multi_count   = data[bced_pkg::CLICK_W-1:0];
                default: ;
            endcase
        endfunction

        function void bump_ticks();
            if (ticks != 16'hFFFF)
                ticks++;
        endfunction

        function void bump_clicks();
            if (clicks != 8'hFF)
                clicks++;
        endfunction

        // Advance one tick and queue the result beat it owes.
        function void take_tick(logic pin);
            logic              level;
            logic              rise;
            bced_pkg::t_event  code;
            bced_pkg::t_result beat;
            level      = pin ^ cfg.pin_invert;
            rise       = level & ~last_level;
            last_level = level;
            code       = bced_pkg::EV_NONE;
            case (state)
                bced_pkg::ST_IDLE: begin
                    ticks = '0;
                    if (rise) begin
                        bump_clicks();
                        pend  = bced_pkg::EV_EDGE;
                        state = bced_pkg::ST_PRESS_EDGE;
                    end else begin
                        clicks = '0;
                        pend   = bced_pkg::EV_NONE;
                    end
                end
                bced_pkg::ST_PRESS_CHECK: begin
                    if (!level) begin
                        if (clicks >= cfg.multi_count) begin
                            ticks  = '0;
                            clicks = '0;
                            pend   = bced_pkg::EV_MULTI;
                            state  = bced_pkg::ST_MULTI;
                        end else if (ticks >= cfg.long_ticks) begin
                            ticks = '0;
                            pend  = bced_pkg::EV_LONG;
                            state = bced_pkg::ST_RELEASE_CHECK;
                        end else if (ticks >= cfg.short_ticks) begin
                            ticks = '0;
                            pend  = bced_pkg::EV_SHORT;
                            state = bced_pkg::ST_RELEASE_CHECK;
                        end else begin
                            // burr: counts are left alone
                            pend  = bced_pkg::EV_NONE;
                            state = bced_pkg::ST_RELEASE_CHECK;
                        end
                    end else begin
                        bump_ticks();
                        if (ticks >= cfg.hold_ticks && pend != bced_pkg::EV_HELD) begin
                            pend  = bced_pkg::EV_HELD;
                            state = bced_pkg::ST_PRESS_HELD;
                        end
                    end
                end
                bced_pkg::ST_RELEASE_CHECK: begin
                    if (rise) begin
                        if (pend != bced_pkg::EV_NONE) begin
                            bump_clicks();
                            ticks = '0;
                        end
                        state = bced_pkg::ST_PRESS_CHECK;
                    end else begin
                        bump_ticks();
                        if (ticks > cfg.release_ticks) begin
                            ticks  = '0;
                            clicks = '0;
                            if (pend == bced_pkg::EV_SHORT)
                                state = bced_pkg::ST_SHORT;
                            else if (pend == bced_pkg::EV_LONG)
                                state = bced_pkg::ST_LONG;
                            else
                                state = bced_pkg::ST_IDLE;
                        end
                    end
                end
                bced_pkg::ST_PRESS_EDGE, bced_pkg::ST_PRESS_HELD: begin
                    code  = pend;
                    state = bced_pkg::ST_PRESS_CHECK;
                end
                bced_pkg::ST_SHORT, bced_pkg::ST_MULTI, bced_pkg::ST_LONG: begin
                    code  = pend;
                    state = bced_pkg::ST_IDLE;
                end
                default: state = bced_pkg::ST_IDLE;
            endcase
            beat.event_code = code;
            beat.pressed    = level;
            owed.push_back(beat);
        endfunction

        // Compare a result beat with the oldest owed one; empty string on a match.
        function string match_beat(logic [2:0] code, logic level);
            bced_pkg::t_result want;
            string             note;
            note = "";
            if (owed.size() == 0)
                return $sformatf("result beat code %0d pressed %b with nothing owed",
                                 code, level);
            want = owed.pop_front();
            if (code !== want.event_code)
                note = $sformatf("event_code %0d, want %0d (%s)", code, want.event_code,
                                 want.event_code.name());
            if (level !== want.pressed)
                note = {note, $sformatf(" pressed %b, want %b", level, want.pressed)};
            return note;
        endfunction
    endclass

    logic                          clk;
    logic                          rst_n;
    logic                          in_valid;
    logic                          in_stall;
    logic                          pin_level;
    logic                          out_valid;
    logic                          out_stall;
    logic [2:0]                    event_code;
    logic                          pressed;
    logic                          cfg_valid;
    logic                          cfg_ready;
    logic [bced_pkg::IDX_W-1:0]    cfg_index;
    logic [bced_pkg::DATA_W-1:0]   cfg_data;

    button_tracker tracker;
    int            errors;
    int            sent;      // ticks accepted so far
    bit            quiet;     // drop all idling on both sides while set

    button_click_event_detector u_dut (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .o_in_stall   (in_stall),
        .i_pin_level  (pin_level),
        .o_out_valid  (out_valid),
        .i_out_stall  (out_stall),
        .o_event_code (event_code),
        .o_pressed    (pressed),
        .i_cfg_valid  (cfg_valid),
        .o_cfg_ready  (cfg_ready),
        .i_cfg_index  (cfg_index),
        .i_cfg_data   (cfg_data)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    task automatic flag(input string what);
        errors++;
        $display("[%0t] mismatch: %s", $time, what);
    endtask

    function automatic int draw_pause();
        return quiet ? 0 : $urandom_range(0, 17);
    endfunction

    // Clamp a threshold to a stimulus length that stays short.
    function automatic int span(input logic [15:0] t);
        return (t > 24) ? 24 : int'(t);
    endfunction

    // Thresholds: mostly small, sometimes zero or all ones.
    function automatic logic [15:0] pick_ticks();
        case ($urandom_range(0, 9))
            0:       return 16'h0000;
            1:       return 16'hFFFF;
            default: return 16'($urandom_range(1, 12));
        endcase
    endfunction

    // Send one tick: idle a random number of cycles, then hold the beat until taken.
    task automatic send_pin(input logic pin);
        int pause;
        pause = draw_pause();
        repeat (pause) begin
            @(negedge clk);
            in_valid <= 1'b0;
        end
        @(negedge clk);
        in_valid  <= 1'b1;
        pin_level <= pin;
        do @(posedge clk); while (in_stall);
        tracker.take_tick(pin);
        sent++;
    endtask

    // Drive a polarity-corrected level; the raw pin follows the current pin_invert.
    task automatic send_level(input logic level, input int count);
        repeat (count) send_pin(level ^ tracker.cfg.pin_invert);
    endtask

    task automatic press(input int down, input int up);
        send_level(1'b1, down);
        send_level(1'b0, up);
    endtask

    // Stop sending and wait until every owed result beat has come back.
    task automatic settle();
        @(negedge clk);
        in_valid <= 1'b0;
        while (tracker.owed.size() != 0) @(posedge clk);
    endtask

    // Leaves valid high so that writes run back to back; configure drops it.
    task automatic write_reg(input logic [bced_pkg::IDX_W-1:0] idx,
                             input logic [bced_pkg::DATA_W-1:0] data);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge clk); while (!cfg_ready);
        tracker.write_reg(idx, data);
    endtask

    // Write all six registers with the block idle; optionally hit the unmapped indexes.
    task automatic configure(input logic [15:0] polarity, input logic [15:0] short_t,
                             input logic [15:0] long_t, input logic [15:0] hold_t,
                             input logic [15:0] rel_t, input logic [15:0] multi_c,
                             input bit spare);
        settle();
        write_reg(bced_pkg::REG_PIN_INVERT, polarity);
        write_reg(bced_pkg::REG_SHORT_TICKS, short_t);
        write_reg(bced_pkg::REG_LONG_TICKS, long_t);
        write_reg(bced_pkg::REG_HOLD_TICKS, hold_t);
        write_reg(bced_pkg::REG_RELEASE_TICKS, rel_t);
        write_reg(bced_pkg::REG_MULTI_COUNT, multi_c);
        if (spare)
            for (int idx = bced_pkg::REG_MULTI_COUNT + 1; idx < (1 << bced_pkg::IDX_W);
                 idx++)
                write_reg(bced_pkg::IDX_W'(idx), 16'($urandom_range(0, 65535)));
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Result side: stall a random number of cycles ahead of each beat.
    initial begin
        int n;
        @(posedge rst_n);
        forever begin
            n = draw_pause();
            repeat (n) begin
                @(negedge clk);
                out_stall <= 1'b1;
            end
            @(negedge clk);
            out_stall <= 1'b0;
            do @(posedge clk); while (!(out_valid && !out_stall));
        end
    end

    // Check every result beat taken at a rising edge.
    always @(posedge clk) begin
        string note;
        if (rst_n && out_valid && !out_stall) begin
            note = tracker.match_beat(event_code, pressed);
            if (note != "")
                flag(note);
        end
    end

    initial begin
        int start;
        int mark;
        int phase;
        int down;
        logic [15:0] lg;
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        pin_level = 1'b0;
        out_stall = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        errors    = 0;
        sent      = 0;
        quiet     = 1'b0;
        tracker   = new();
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed: reset settings first (inverted pin, pin low means pressed), then a
        // burr press, an edge, a short click, held plus long, and a quick double click.
        send_pin(1'b1);
        send_pin(1'b0);
        send_pin(1'b0);
        send_pin(1'b1);
        // pin_invert cleared through a wide write; multi count 2 with junk upper byte
        configure(16'hFFFE, 16'd1, 16'd4, 16'd3, 16'd1, 16'h5A02, 1'b0);
        press(1, 2);
        press(3, 3);
        press(6, 3);
        press(1, 1);
        press(1, 3);

        // Random: well-formed presses with random lengths, salted with pin noise.
        start = sent;
        phase = 0;
        while (sent - start < 700) begin
            case (phase)
                // zero multi count through a wide write; also hit unmapped indexes
                0: configure(16'($urandom_range(0, 65535)), pick_ticks(), pick_ticks(),
                             pick_ticks(), pick_ticks(), 16'h0100, 1'b1);
                1: configure(16'($urandom_range(0, 65535)), 16'h0000, 16'h0000, 16'h0000,
                             16'h0000, {8'($urandom_range(0, 255)), 8'd1}, 1'b0);
                2: configure(16'($urandom_range(0, 65535)), 16'hFFFF, 16'hFFFF, 16'hFFFF,
                             16'hFFFF, 16'hFFFF, 1'b0);
                default: configure(16'($urandom_range(0, 65535)), pick_ticks(),
                                   pick_ticks(), pick_ticks(), pick_ticks(),
                                   {8'($urandom_range(0, 255)),
                                    8'($urandom_range(1, 5))}, 1'b0);
            endcase
            quiet = (phase % 4 == 3);
            lg = (tracker.cfg.long_ticks > tracker.cfg.hold_ticks) ?
                 tracker.cfg.long_ticks : tracker.cfg.hold_ticks;
            mark = sent;
            while (sent - mark < 60) begin
                if ($urandom_range(0, 9) < 8) begin
                    down = $urandom_range(1, span(lg) + 3);
                    press(down, $urandom_range(1, span(tracker.cfg.release_ticks) + 3));
                end else begin
                    repeat ($urandom_range(1, 6)) send_pin(1'($urandom_range(0, 1)));
                end
            end
            phase++;
        end

        // Drain with a bound, then let the registered result play out.
        quiet = 1'b0;
        @(negedge clk);
        in_valid <= 1'b0;
        for (int w = 0; w < 200 && tracker.owed.size() != 0; w++) @(posedge clk);
        repeat (4) @(posedge clk);
        if (tracker.owed.size() != 0)
            flag($sformatf("%0d result beats never arrived", tracker.owed.size()));

        if (errors == 0)
            $display("button_click_event_detector verification clean");
        else
            $display("button_click_event_detector verification failed");
        $finish;
    end

    // Watchdog: several times the slowest legal run under full idling on both sides.
    initial begin
        #2_000_000;
        $display("button_click_event_detector verification failed");
        $finish;
    end

endmodule

// File: files.f
rtl/bced_pkg.sv
rtl/bced_cfg_regs.sv
rtl/bced_fsm.sv
rtl/button_click_event_detector.sv
tb/tb.sv
